>>> sv/multicast_membership_table_top_macros.svh
// Assertion macros for the multicast membership table.
// Used by multicast_membership_table_top.sv; no other dependencies.
`ifndef MULTICAST_MEMBERSHIP_TABLE_TOP_MACROS_SVH
`define MULTICAST_MEMBERSHIP_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Plain property, checked at every rising clock edge outside reset.
`define MMT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Same-cycle implication.
`define MMT_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define MMT_ASSERT(lbl, clk, rstn, prop, msg)
`define MMT_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> sv/mmt_pkg.sv
// Package for the multicast membership table: codes, entry type, cell control.
// No dependencies.
package mmt_pkg;

  localparam int unsigned EntriesDef = 32;
  localparam int unsigned MaxOut     = 32;   // leaves per drop-all request
  localparam int unsigned CntW       = $clog2(MaxOut + 1);

  // operation codes
  localparam logic [1:0] OP_JOIN  = 2'd0;
  localparam logic [1:0] OP_LEAVE = 2'd1;
  localparam logic [1:0] OP_DROP  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_NOTAVAIL = 2'd2;

  // igmp action codes
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_JOIN  = 2'd1;
  localparam logic [1:0] ACT_LEAVE = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [7:0]  owner;
    logic [31:0] group;
    logic [31:0] iface;
  } entry_t;

  typedef struct packed {
    logic shift;  // take the neighbor's entry
    logic load;   // write a new membership
  } cell_ctrl_t;

endpackage

>>> sv/mmt_ifc.sv
// Valid/ready channel interfaces for the multicast membership table.
// No dependencies.
interface mmt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  owner_id;
  logic [31:0] group_addr;
  logic [31:0] iface_addr;
  logic        join_accepted;

  modport source (output valid, operation, owner_id, group_addr, iface_addr,
                  join_accepted, input ready);
  modport sink   (input valid, operation, owner_id, group_addr, iface_addr,
                  join_accepted, output ready);
endinterface

interface mmt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  igmp_action;
  logic [31:0] igmp_group;
  logic [31:0] igmp_iface;
  logic        last;

  modport source (output valid, status, igmp_action, igmp_group, igmp_iface, last,
                  input ready);
  modport sink   (input valid, status, igmp_action, igmp_group, igmp_iface, last,
                  output ready);
endinterface

>>> sv/mmt_cell.sv
// One slot of the membership ring: valid bit plus owner/group/iface.
// Depends on mmt_pkg.
module mmt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mmt_pkg::cell_ctrl_t ctrl_i,
  input  mmt_pkg::entry_t    shift_i,
  input  mmt_pkg::entry_t    load_i,
  output mmt_pkg::entry_t    q_o
);
  import mmt_pkg::*;

  entry_t      entry_d, entry_q;
  logic        valid_q;
  logic [7:0]  owner_q;
  logic [31:0] group_q, iface_q;

  assign entry_q = '{valid: valid_q, owner: owner_q, group: group_q, iface: iface_q};

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = load_i;
    end else if (ctrl_i.shift) begin
      entry_d = shift_i;
    end
  end

  // only the valid bit is reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    owner_q <= entry_d.owner;
    group_q <= entry_d.group;
    iface_q <= entry_d.iface;
  end

  assign q_o = entry_q;

endmodule

>>> sv/multicast_membership_table_top.sv
// Multicast membership table: ENTRIES slots held in a rotating ring of cells.
// An input word is accepted only while idle, scanned over all ENTRIES slots as the
// ring rotates, then finished in a done state that loads the output register. Join,
// leave and op 3 give one word (op 3 skips the scan), drop-all one word per removed
// entry, or one word if none (rotation stalls on output back-pressure).
// Reset: valid bits clear at once, no clearing pass; stored addresses are not reset.
`include "multicast_membership_table_top_macros.svh"

module multicast_membership_table_top #(
  parameter int unsigned ENTRIES = mmt_pkg::EntriesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  mmt_in_if.sink    in_i,
  mmt_out_if.source out_o
);
  import mmt_pkg::*;

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // ---------------------------------------------------------------------------
  // Request and scan bookkeeping
  // ---------------------------------------------------------------------------
  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;        // slot currently at the ring head
  logic            found_q, found_d;    // exact match seen
  logic            free_q, free_d;      // free slot seen (join)
  logic [IdxW-1:0] slot_q, slot_d;      // lowest free slot
  logic [CntW-1:0] cnt_q, cnt_d;        // leaves taken by this drop-all
  logic            remain_q, remain_d;  // owner entries left behind
  logic            pend_valid_q, pend_valid_d;
  logic [31:0]     pend_grp_q, pend_grp_d;
  logic [31:0]     pend_ifc_q, pend_ifc_d;

  logic [1:0]  op_q;
  logic [7:0]  own_q;
  logic [31:0] grp_q, ifc_q;
  logic        acc_q;

  // output register
  logic        out_valid_q;
  logic [1:0]  out_status_q, out_action_q;
  logic [31:0] out_grp_q, out_ifc_q;
  logic        out_last_q;

  // ---------------------------------------------------------------------------
  // Cell ring: cell g takes cell g+1 on each step; the head (cell 0) is fed back
  // into the tail, possibly with its valid bit cleared. After ENTRIES steps the
  // ring is back in slot order, so cell g holds slot g between scans.
  // ---------------------------------------------------------------------------
  entry_t            cell_q [ENTRIES];
  entry_t            head, feedback, new_entry;
  logic              step, kill, join_wr;
  logic [ENTRIES-1:0] load_vec, valid_vec;

  assign head      = cell_q[0];
  assign new_entry = '{valid: 1'b1, owner: own_q, group: grp_q, iface: ifc_q};

  always_comb begin
    feedback       = head;
    feedback.valid = head.valid & ~kill;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     shift_in;

    assign load_vec[g]  = join_wr && (slot_q == IdxW'(g));
    assign valid_vec[g] = cell_q[g].valid;
    assign ctrl.shift   = step;
    assign ctrl.load    = load_vec[g];

    if (g == ENTRIES - 1) begin : g_tail
      assign shift_in = feedback;
    end else begin : g_body
      assign shift_in = cell_q[g+1];
    end

    mmt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .shift_i (shift_in),
      .load_i  (new_entry),
      .q_o     (cell_q[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Head compare and scan control
  // ---------------------------------------------------------------------------
  logic in_fire, can_emit, load_out, scan_emit;
  logic head_match, owner_hit, drop_take;
  logic [1:0]  res_status, res_action;
  logic [31:0] res_grp, res_ifc;
  logic        res_last;

  assign in_fire    = in_i.valid && in_i.ready;
  assign can_emit   = !out_valid_q || out_o.ready;
  assign owner_hit  = head.valid && (head.owner == own_q);
  assign head_match = owner_hit && (head.group == grp_q) && (head.iface == ifc_q);
  assign drop_take  = owner_hit && (cnt_q < CntW'(MaxOut));

  // drop-all needs room in the output register before it may pass an entry
  assign step = (state_q == S_SCAN) && ((op_q != OP_DROP) || can_emit);

  always_comb begin
    kill = 1'b0;
    if (step) begin
      if (op_q == OP_LEAVE) begin
        kill = head_match && !found_q;
      end else if (op_q == OP_DROP) begin
        kill = drop_take;
      end
    end
  end

  // a new drop-all hit pushes out the previous one, which is then known not last
  assign scan_emit = step && (op_q == OP_DROP) && drop_take && pend_valid_q;

  // final word of the request
  always_comb begin
    res_status = ST_OK;
    res_action = ACT_NONE;
    res_grp    = '0;
    res_ifc    = '0;
    res_last   = 1'b1;
    join_wr    = 1'b0;
    unique case (op_q)
      OP_JOIN: begin
        if (found_q) begin
          res_status = ST_OK;
        end else if (!free_q) begin
          res_status = ST_NOSPACE;
        end else if (!acc_q) begin
          res_status = ST_NOTAVAIL;
        end else begin
          res_action = ACT_JOIN;
          res_grp    = grp_q;
          res_ifc    = ifc_q;
          join_wr    = (state_q == S_DONE) && can_emit;
        end
      end
      OP_LEAVE: begin
        if (found_q) begin
          res_action = ACT_LEAVE;
          res_grp    = grp_q;
          res_ifc    = ifc_q;
        end else begin
          res_status = ST_NOTAVAIL;
        end
      end
      OP_DROP: begin
        if (pend_valid_q) begin
          res_action = ACT_LEAVE;
          res_grp    = pend_grp_q;
          res_ifc    = pend_ifc_q;
          res_last   = !remain_q;
        end
      end
      default: begin
        // unused code: plain ok word
      end
    endcase
  end

  assign load_out = scan_emit || ((state_q == S_DONE) && can_emit);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    found_d      = found_q;
    free_d       = free_q;
    slot_d       = slot_q;
    cnt_d        = cnt_q;
    remain_d     = remain_q;
    pend_valid_d = pend_valid_q;
    pend_grp_d   = pend_grp_q;
    pend_ifc_d   = pend_ifc_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          found_d      = 1'b0;
          free_d       = 1'b0;
          cnt_d        = '0;
          remain_d     = 1'b0;
          pend_valid_d = 1'b0;
          idx_d        = '0;
          if ((in_i.operation == OP_JOIN) || (in_i.operation == OP_LEAVE) ||
              (in_i.operation == OP_DROP)) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (step) begin
          unique case (op_q)
            OP_JOIN: begin
              if (head_match) found_d = 1'b1;
              if (!head.valid && !free_q) begin
                free_d = 1'b1;
                slot_d = idx_q;
              end
            end
            OP_LEAVE: begin
              if (head_match) found_d = 1'b1;
            end
            OP_DROP: begin
              if (drop_take) begin
                cnt_d        = cnt_q + CntW'(1);
                pend_valid_d = 1'b1;
                pend_grp_d   = head.group;
                pend_ifc_d   = head.iface;
              end else if (owner_hit) begin
                remain_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
          if (idx_q == IdxW'(ENTRIES - 1)) begin
            idx_d   = '0;
            state_d = S_DONE;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      S_DONE: begin
        if (can_emit) begin
          state_d      = S_IDLE;
          pend_valid_d = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      found_q      <= 1'b0;
      free_q       <= 1'b0;
      cnt_q        <= '0;
      remain_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      found_q      <= found_d;
      free_q       <= free_d;
      cnt_q        <= cnt_d;
      remain_q     <= remain_d;
      pend_valid_q <= pend_valid_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    pend_grp_q <= pend_grp_d;
    pend_ifc_q <= pend_ifc_d;
    if (in_fire) begin
      op_q  <= in_i.operation;
      own_q <= in_i.owner_id;
      grp_q <= in_i.group_addr;
      ifc_q <= in_i.iface_addr;
      acc_q <= in_i.join_accepted;
    end
    if (scan_emit) begin
      out_status_q <= ST_OK;
      out_action_q <= ACT_LEAVE;
      out_grp_q    <= pend_grp_q;
      out_ifc_q    <= pend_ifc_q;
      out_last_q   <= 1'b0;
    end else if (load_out) begin
      out_status_q <= res_status;
      out_action_q <= res_action;
      out_grp_q    <= res_grp;
      out_ifc_q    <= res_ifc;
      out_last_q   <= res_last;
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.igmp_action = out_action_q;
  assign out_o.igmp_group  = out_grp_q;
  assign out_o.igmp_iface  = out_ifc_q;
  assign out_o.last        = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `MMT_ASSERT(a_single_load, clk_i, rst_ni, $onehot0(load_vec), "more than one cell written")
  `MMT_ASSERT_IMPLY(a_join_free, clk_i, rst_ni, join_wr, !valid_vec[slot_q],
                    "join overwrites a valid entry")
  `MMT_ASSERT_IMPLY(a_pend_drop, clk_i, rst_ni, pend_valid_q, op_q == OP_DROP,
                    "pending leave outside drop-all")
  `MMT_ASSERT_IMPLY(a_emit_room, clk_i, rst_ni, load_out, can_emit,
                    "output word loaded over an untaken word")
  `MMT_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(MaxOut), "drop-all leave count overflow")

endmodule

>>> sim/tb_multicast_membership_table_top.sv
// Self-checking testbench for multicast_membership_table_top.
// Depends on mmt_pkg (codes, entry type) and mmt_ifc.sv (valid/ready channels).
// Runs directed and random join/leave/drop-all words with random stalls on both sides.
module tb_multicast_membership_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mmt_pkg::*;

  localparam int          Slots      = EntriesDef;
  localparam logic [1:0]  OpUnused   = 2'd3;   // reserved opcode, answered with a plain ok word
  localparam int          HoldCycles = 400;    // long output stall, fills the block up
  localparam int          HoldAfter  = 80;     // input words accepted before the stall starts
  localparam int          RandWords  = 210;

  // one request word as offered on the input channel
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  owner;
    logic [31:0] group;
    logic [31:0] iface;
    logic        accept;
  } request_t;

  // one answer word on the output channel
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  action;
    logic [31:0] group;
    logic [31:0] iface;
    logic        last;
  } igmp_word_t;

  logic clk_i;
  logic rst_ni;

  mmt_in_if  req_if ();
  mmt_out_if rsp_if ();

  multicast_membership_table_top #(
    .ENTRIES(Slots)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  // ---------------------------------------------------------------------------
  // Shadow membership table and the answers it predicts.
  // ---------------------------------------------------------------------------
  entry_t     shadow [Slots] = '{default: '0};
  igmp_word_t pending_results [$];   // answers owed by the block, oldest first
  request_t   req_backlog [$];       // words still to be offered
  request_t   joined_pool [$];       // memberships joined so far, used to aim leaves

  int mismatches   = 0;
  int words_in     = 0;              // accepted input words (NBA, read by the stall process)
  int words_out    = 0;
  int joins_seen   = 0;
  int leaves_seen  = 0;
  int nospace_seen = 0;

  function automatic void queue_result(logic [1:0] status, logic [1:0] action,
                                       logic [31:0] group, logic [31:0] iface,
                                       logic last);
    igmp_word_t w;
    w.status = status;
    w.action = action;
    w.group  = group;
    w.iface  = iface;
    w.last   = last;
    pending_results.push_back(w);
  endfunction

  function automatic bit holds_membership(int i, request_t rq);
    return shadow[i].valid && shadow[i].owner == rq.owner &&
           shadow[i].group == rq.group && shadow[i].iface == rq.iface;
  endfunction

  // Applies one accepted request to the shadow table, queueing its answers.
  function automatic void predict_membership(request_t rq);
    int slot;
    int n;
    bit remain;
    slot   = -1;
    n      = 0;
    remain = 1'b0;
    case (rq.op)
      OP_JOIN: begin
        // an existing membership wins over everything, even a full table
        for (int i = 0; i < Slots; i++) begin
          if (!shadow[i].valid) begin
            if (slot < 0) slot = i;
          end else if (holds_membership(i, rq)) begin
            queue_result(ST_OK, ACT_NONE, '0, '0, 1'b1);
            return;
          end
        end
        if (slot < 0) begin
          queue_result(ST_NOSPACE, ACT_NONE, '0, '0, 1'b1);
        end else if (!rq.accept) begin
          queue_result(ST_NOTAVAIL, ACT_NONE, '0, '0, 1'b1);
        end else begin
          shadow[slot].valid = 1'b1;
          shadow[slot].owner = rq.owner;
          shadow[slot].group = rq.group;
          shadow[slot].iface = rq.iface;
          queue_result(ST_OK, ACT_JOIN, rq.group, rq.iface, 1'b1);
        end
      end
      OP_LEAVE: begin
        for (int i = 0; i < Slots; i++) begin
          if (holds_membership(i, rq)) begin
            shadow[i].valid = 1'b0;
            queue_result(ST_OK, ACT_LEAVE, rq.group, rq.iface, 1'b1);
            return;
          end
        end
        queue_result(ST_NOTAVAIL, ACT_NONE, '0, '0, 1'b1);
      end
      OP_DROP: begin
        // one leave per owned slot, lowest slot first, capped per request
        for (int i = 0; i < Slots; i++) begin
          if (!shadow[i].valid || shadow[i].owner != rq.owner) continue;
          if (n >= MaxOut) begin
            remain = 1'b1;
            break;
          end
          queue_result(ST_OK, ACT_LEAVE, shadow[i].group, shadow[i].iface, 1'b0);
          shadow[i].valid = 1'b0;
          n++;
        end
        if (n == 0) queue_result(ST_OK, ACT_NONE, '0, '0, 1'b1);
        else if (!remain) pending_results[$].last = 1'b1;
      end
      default: queue_result(ST_OK, ACT_NONE, '0, '0, 1'b1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic void add_request(logic [1:0] op, logic [7:0] owner, logic [31:0] group,
                                      logic [31:0] iface, logic accept);
    request_t rq;
    rq.op     = op;
    rq.owner  = owner;
    rq.group  = group;
    rq.iface  = iface;
    rq.accept = accept;
    req_backlog.push_back(rq);
    if (op == OP_JOIN && accept) joined_pool.push_back(rq);
  endfunction

  // Mostly a handful of owners so that drop-all finds several entries.
  function automatic logic [7:0] pick_owner();
    logic [7:0] favorites [5] = '{8'h00, 8'h01, 8'h5A, 8'hA5, 8'hFF};
    if ($urandom_range(0, 3) != 0) return favorites[$urandom_range(0, 4)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic request_t pooled();
    return joined_pool[$urandom_range(0, joined_pool.size() - 1)];
  endfunction

  // Gap lengths: mostly short, a few long, with calm stretches of no gaps at all.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, timeout.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // worst case is far below this; only a hung handshake gets here
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers backlog words, predicts on acceptance, random idle gaps between words.
  // ---------------------------------------------------------------------------
  request_t offered;
  int       send_gap  = 0;
  int       send_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid         <= 1'b0;
      req_if.operation     <= '0;
      req_if.owner_id      <= '0;
      req_if.group_addr    <= '0;
      req_if.iface_addr    <= '0;
      req_if.join_accepted <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_membership(offered);
        words_in <= words_in + 1;
      end
      // channel free: either nothing offered or the offered word just went in
      if (!req_if.valid || req_if.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          offered = req_backlog.pop_front();
          req_if.operation     <= offered.op;
          req_if.owner_id      <= offered.owner;
          req_if.group_addr    <= offered.group;
          req_if.iface_addr    <= offered.iface;
          req_if.join_accepted <= offered.accept;
          req_if.valid         <= 1'b1;
          send_gap = pick_gap(send_calm);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long output stall, once, after enough words went in. The sender keeps
  // offering, so the block backs up and has to drop its input ready.
  // ---------------------------------------------------------------------------
  int   hold_cycles;
  logic hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cycles <= 0;
      hold_done   <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && words_in >= HoldAfter) begin
      hold_cycles <= HoldCycles;
      hold_done   <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every accepted answer word against the oldest prediction.
  // ---------------------------------------------------------------------------
  int recv_gap  = 0;
  int recv_calm = 0;

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    igmp_word_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        words_out++;
        if (pending_results.size() == 0) begin
          $display("%0t ns: unexpected answer word, expected none, got status %0d action %0d",
                   $time, rsp_if.status, rsp_if.igmp_action);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("status",      want.status, rsp_if.status);
          check_field("igmp_action", want.action, rsp_if.igmp_action);
          check_field("igmp_group",  want.group,  rsp_if.igmp_group);
          check_field("igmp_iface",  want.iface,  rsp_if.igmp_iface);
          check_field("last",        want.last,   rsp_if.last);
          if (want.action == ACT_JOIN)    joins_seen++;
          if (want.action == ACT_LEAVE)   leaves_seen++;
          if (want.status == ST_NOSPACE)  nospace_seen++;
        end
      end
      if (hold_cycles != 0) begin
        rsp_if.ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        recv_gap = pick_gap(recv_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    request_t   rq;
    int         r;
    bit         filling;
    logic [1:0] op;

    // directed: empty table, field extremes, repeat join, refusal, misses,
    // multi-entry drop-all in slot order, reserved opcode
    add_request(OP_LEAVE, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1); // leave, no match
    add_request(OP_DROP,  8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1); // drop, nothing owned
    add_request(OP_JOIN,  8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1);
    add_request(OP_JOIN,  8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0); // already a member
    add_request(OP_JOIN,  8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0); // refused externally
    add_request(OP_JOIN,  8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_request(OP_JOIN,  8'hFF, 32'hE000_0001, 32'h0000_0000, 1'b1);
    add_request(OP_JOIN,  8'hFF, 32'hE000_0001, 32'hC0A8_0001, 1'b1);
    add_request(OP_JOIN,  8'h5A, 32'hE000_0001, 32'h0000_0000, 1'b1);
    add_request(OpUnused, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_request(OP_LEAVE, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1);
    add_request(OP_LEAVE, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1); // gone already
    add_request(OP_LEAVE, 8'hFF, 32'hE000_0001, 32'h0000_0002, 1'b1); // interface differs
    add_request(OP_LEAVE, 8'hA5, 32'hE000_0001, 32'h0000_0000, 1'b1); // owner differs
    add_request(OP_DROP,  8'hFF, 32'h0000_0000, 32'h0000_0000, 1'b0); // three leaves
    add_request(OP_DROP,  8'hFF, 32'h0000_0000, 32'h0000_0000, 1'b0);
    add_request(OpUnused, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0);
    add_request(OP_LEAVE, 8'h5A, 32'hE000_0001, 32'h0000_0000, 1'b1);

    // random: join-heavy stretches that fill the table past capacity,
    // alternating with leave/drop-heavy stretches that drain it
    for (int k = 0; k < RandWords; k++) begin
      filling = (k % 105) < 55;
      r = $urandom_range(0, 99);
      if (filling) op = (r < 90) ? OP_JOIN : (r < 94) ? OP_LEAVE : (r < 97) ? OP_DROP : OpUnused;
      else         op = (r < 35) ? OP_JOIN : (r < 70) ? OP_LEAVE : (r < 95) ? OP_DROP : OpUnused;

      rq.owner  = pick_owner();
      rq.group  = ($urandom_range(0, 1) != 0) ? $urandom : {8'hE0, 16'h0000, 8'($urandom)};
      rq.iface  = ($urandom_range(0, 9) < 3) ? 32'h0 : $urandom;
      rq.accept = ($urandom_range(0, 9) != 0);
      r = $urandom_range(0, 99);
      case (op)
        OP_JOIN: begin
          if (r < 10 && joined_pool.size() != 0) begin
            rq = pooled();
            rq.accept = 1'($urandom_range(0, 1));
          end
        end
        OP_LEAVE: begin
          if (r < 80 && joined_pool.size() != 0) begin
            rq = pooled();
            if (r >= 70) rq.iface = rq.iface ^ 32'h1;   // near miss
          end
        end
        OP_DROP: begin
          if (r < 80 && joined_pool.size() != 0) rq.owner = pooled().owner;
        end
        default: ;
      endcase
      add_request(op, rq.owner, rq.group, rq.iface, rq.accept);
    end

    @(posedge rst_ni);
    while (req_backlog.size() != 0 || req_if.valid || pending_results.size() != 0)
      @(posedge clk_i);
    // a stray word would show up within one more scan of the table
    repeat (2 * Slots + 8) @(posedge clk_i);

    $display("Ran %0d request words, checked %0d answer words: %0d joins, %0d leaves,",
             words_in, words_out, joins_seen, leaves_seen);
    $display("%0d joins refused on a full table, one %0d-cycle output stall.",
             nospace_seen, HoldCycles);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
